// File: sv/rits_pkg.sv
// Package for the radix integer-to-symbols converter: constants, types, symbol lookup.
// Used by every module of the block but rits_ram; depends on nothing.
package rits_pkg;

    localparam int C_VALUE_BITS  = 32;
    localparam int C_RADIX_W     = 5;
    localparam int C_SYMBOL_W    = 8;
    localparam int C_DIGIT_W     = 4;
    localparam int C_TABLE_W     = 128;
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_DIV_STEPS   = 8;
    localparam int C_PADDR_W     = 5;
    localparam int C_PDATA_W     = 64;
    localparam int C_REG_IDX_W   = 2;

    localparam logic [C_RADIX_W-1:0]  C_MIN_RADIX = 5'd2;
    localparam logic [C_RADIX_W-1:0]  C_MAX_RADIX = 5'd16;
    localparam logic [C_SYMBOL_W-1:0] C_SYM_MINUS = 8'h2D;
    localparam logic [C_SYMBOL_W-1:0] C_SYM_PLUS  = 8'h2B;
    localparam logic [C_SYMBOL_W-1:0] C_SYM_SPACE = 8'h20;
    localparam logic [C_SYMBOL_W-1:0] C_SYM_NONE  = 8'h00;
    localparam logic [C_SYMBOL_W-1:0] C_CTRL_LO   = 8'd9;
    localparam logic [C_SYMBOL_W-1:0] C_CTRL_HI   = 8'd13;

    localparam logic [C_RADIX_W-1:0] C_RADIX_RST   = 5'd10;
    localparam logic [63:0]          C_SYM_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [63:0]          C_SYM_HIGH_RST = 64'h0000_0000_0000_3938;

    typedef enum logic [C_REG_IDX_W-1:0] {
        REG_RADIX    = 2'd0,
        REG_SYM_LOW  = 2'd1,
        REG_SYM_HIGH = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic bad;
        logic neg;
    } t_job_ctl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_READ,
        BK_LOAD,
        BK_BAD
    } t_back_state;

    function automatic logic [C_SYMBOL_W-1:0] f_symbol_at(
        input logic [C_TABLE_W-1:0] tbl,
        input logic [C_DIGIT_W-1:0] d
    );
        return tbl[{d, 3'b000} +: C_SYMBOL_W];
    endfunction

endpackage

// File: sv/rits_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module rits_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/rits_front.sv
// Front end: accepts input items, checks the symbol table, forms sign and magnitude.
// Depends on rits_pkg; feeds rits_queue.
module rits_front #(
    parameter int VALUE_BITS = rits_pkg::C_VALUE_BITS
) (
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_value,
    input  logic [rits_pkg::C_RADIX_W-1:0]    i_radix,
    input  logic [rits_pkg::C_TABLE_W-1:0]    i_table,
    input  logic                              i_full,
    output logic                              o_push,
    output rits_pkg::t_job_ctl                o_job_ctl,
    output logic [VALUE_BITS-1:0]             o_job_mag
);
    import rits_pkg::*;

    logic [VALUE_BITS-1:0] val;
    logic [C_SYMBOL_W-1:0] sym_i;
    logic                  bad;

    // table check: radix range, forbidden bytes and duplicates among used symbols
    always_comb begin
        bad = (i_radix < C_MIN_RADIX) || (i_radix > C_MAX_RADIX);
        sym_i = C_SYM_NONE;
        for (int i = 0; i < 16; i++) begin
            sym_i = f_symbol_at(i_table, C_DIGIT_W'(i));
            if (C_RADIX_W'(i) < i_radix) begin
                if (sym_i == C_SYM_NONE || sym_i == C_SYM_PLUS || sym_i == C_SYM_MINUS ||
                    sym_i == C_SYM_SPACE || (sym_i >= C_CTRL_LO && sym_i <= C_CTRL_HI)) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < 16; j++) begin
                    if (C_RADIX_W'(j) < i_radix &&
                        f_symbol_at(i_table, C_DIGIT_W'(j)) == sym_i) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign val           = i_value[VALUE_BITS-1:0];
    assign o_job_ctl.bad = bad;
    assign o_job_ctl.neg = val[VALUE_BITS-1];
    // most negative value negates to itself, which is the right unsigned magnitude
    assign o_job_mag     = val[VALUE_BITS-1] ? (VALUE_BITS'(0) - val) : val;
    assign o_stall       = i_full;
    assign o_push        = i_valid && !i_full;
endmodule

// File: sv/rits_queue.sv
// Short FIFO between the front end and the conversion back end.
// Depends on rits_pkg for its depth.
module rits_queue #(
    parameter int DATA_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    import rits_pkg::*;

    localparam int PW = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(C_QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_data [C_QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [NW-1:0]     r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == NW'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end
endmodule

// File: sv/rits_back.sv
// Back end: repeated division by the radix into a digit stack, then symbol output.
// Depends on rits_pkg and rits_ram; pulls jobs from rits_queue.
module rits_back #(
    parameter int VALUE_BITS = rits_pkg::C_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rits_pkg::C_RADIX_W-1:0]    i_radix,
    input  logic [rits_pkg::C_TABLE_W-1:0]    i_table,
    input  logic                              i_job_valid,
    input  rits_pkg::t_job_ctl                i_job_ctl,
    input  logic [VALUE_BITS-1:0]             i_job_mag,
    output logic                              o_job_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rits_pkg::C_SYMBOL_W-1:0]   o_symbol,
    output logic                              o_last,
    output logic                              o_bad_table
);
    import rits_pkg::*;

    localparam int PAD_W = ((VALUE_BITS + C_DIV_STEPS - 1) / C_DIV_STEPS) * C_DIV_STEPS;
    localparam int NSTEP = PAD_W / C_DIV_STEPS;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int AW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CW    = $clog2(VALUE_BITS + 1);

    t_back_state           r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  r_neg, n_neg;
    logic [PAD_W-1:0]      r_dvd, n_dvd;
    logic [C_DIGIT_W-1:0]  r_rem, n_rem;
    logic [SW-1:0]         r_step, n_step;
    logic [C_SYMBOL_W-1:0] r_out_symbol, n_out_symbol;
    logic                  r_out_last, n_out_last;
    logic                  r_out_bad, n_out_bad;

    logic [C_RADIX_W-1:0]  div_t;
    logic [C_DIGIT_W-1:0]  div_rem;
    logic [PAD_W-1:0]      div_q;
    logic                  slot_free;
    logic [CW-1:0]         cnt_m1;
    logic                  ram_we, ram_re;
    logic [C_DIGIT_W-1:0]  ram_rdata;

    // eight restoring steps per cycle; partial remainder stays below the radix
    always_comb begin
        div_q   = r_dvd;
        div_rem = r_rem;
        div_t   = '0;
        for (int k = 0; k < C_DIV_STEPS; k++) begin
            div_t = {div_rem, div_q[PAD_W-1]};
            div_q = {div_q[PAD_W-2:0], 1'b0};
            if (div_t >= i_radix) begin
                div_t    = div_t - i_radix;
                div_q[0] = 1'b1;
            end
            div_rem = div_t[C_DIGIT_W-1:0];
        end
    end

    assign slot_free = !r_out_valid || !i_stall;
    assign cnt_m1    = r_cnt - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_stall;
        n_neg        = r_neg;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_step       = r_step;
        n_out_symbol = r_out_symbol;
        n_out_last   = r_out_last;
        n_out_bad    = r_out_bad;
        o_job_pop    = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_neg     = i_job_ctl.neg;
                    n_dvd     = PAD_W'(i_job_mag);
                    n_rem     = '0;
                    n_step    = '0;
                    n_cnt     = '0;
                    n_state   = i_job_ctl.bad ? BK_BAD : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == SW'(NSTEP - 1)) begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_dvd  = div_q;
                    n_rem  = '0;
                    n_step = '0;
                    if (div_q == '0 || r_cnt == CW'(VALUE_BITS - 1)) begin
                        n_state = r_neg ? BK_SIGN : BK_READ;
                    end
                end else begin
                    n_dvd  = div_q;
                    n_rem  = div_rem;
                    n_step = r_step + SW'(1);
                end
            end
            BK_SIGN: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_symbol = C_SYM_MINUS;
                    n_out_last   = 1'b0;
                    n_out_bad    = 1'b0;
                    n_state      = BK_READ;
                end
            end
            BK_READ: begin
                ram_re  = 1'b1;
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_symbol = f_symbol_at(i_table, ram_rdata);
                    n_out_last   = (r_cnt == CW'(1));
                    n_out_bad    = 1'b0;
                    n_cnt        = cnt_m1;
                    n_state      = (r_cnt == CW'(1)) ? BK_IDLE : BK_READ;
                end
            end
            BK_BAD: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_symbol = C_SYM_NONE;
                    n_out_last   = 1'b1;
                    n_out_bad    = 1'b1;
                    n_state      = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_dvd        <= n_dvd;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_out_symbol <= n_out_symbol;
        r_out_last   <= n_out_last;
        r_out_bad    <= n_out_bad;
    end

    // digit stack, least significant digit at the bottom
    rits_ram #(
        .WIDTH (C_DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (cnt_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_valid     = r_out_valid;
    assign o_symbol    = r_out_symbol;
    assign o_last      = r_out_last;
    assign o_bad_table = r_out_bad;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(VALUE_BITS))
        else $error("digit count beyond value width");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> r_out_last && r_out_symbol == C_SYM_NONE)
        else $error("error item not single with zero symbol");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_IDLE && !i_job_valid |=> r_state == BK_IDLE)
        else $error("back end left idle without a job");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> r_state == BK_IDLE && i_job_valid)
        else $error("job popped while busy");
`endif
endmodule

// File: sv/radix_integer_to_symbols_core.sv
// Flow: an accepted item is in the queue in the next cycle; the back end, one value at a time,
// divides out each digit at 8 quotient bits per cycle over a 32-bit magnitude, then sends a minus
// sign if negative and the digit symbols, or a single error item; the front end takes items while
// the two-entry queue has room.
// Reset: synchronous, active low; registers return to radix 10 and table "0123456789",
// queue and output empty; the digit stack needs no clearing.
module radix_integer_to_symbols_core #(
    parameter int VALUE_BITS = rits_pkg::C_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rits_pkg::C_SYMBOL_W-1:0]   o_symbol,
    output logic                              o_last,
    output logic                              o_bad_table,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rits_pkg::C_PADDR_W-1:0]    paddr,
    input  logic [rits_pkg::C_PDATA_W-1:0]    pwdata,
    output logic [rits_pkg::C_PDATA_W-1:0]    prdata,
    output logic                              pready
);
    import rits_pkg::*;

    localparam int CTL_W  = $bits(t_job_ctl);
    localparam int DATA_W = CTL_W + VALUE_BITS;

    logic [C_RADIX_W-1:0] r_radix;
    logic [63:0]          r_sym_low;
    logic [63:0]          r_sym_high;
    logic [C_TABLE_W-1:0] table_bits;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    logic                  q_full, q_push, q_valid, q_pop;
    logic [DATA_W-1:0]     q_in, q_out;
    t_job_ctl              front_ctl;
    logic [VALUE_BITS-1:0] front_mag;

    assign pready     = 1'b1;
    assign reg_idx    = t_reg_idx'(paddr[C_PADDR_W-1:3]);
    assign cfg_wr     = psel && penable && pwrite;
    assign table_bits = {r_sym_high, r_sym_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= C_RADIX_RST;
            r_sym_low  <= C_SYM_LOW_RST;
            r_sym_high <= C_SYM_HIGH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RADIX:    r_radix    <= pwdata[C_RADIX_W-1:0];
                REG_SYM_LOW:  r_sym_low  <= pwdata;
                REG_SYM_HIGH: r_sym_high <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RADIX:    prdata = C_PDATA_W'(r_radix);
            REG_SYM_LOW:  prdata = r_sym_low;
            REG_SYM_HIGH: prdata = r_sym_high;
            default:      prdata = '0;
        endcase
    end

    rits_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_radix   (r_radix),
        .i_table   (table_bits),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_job_ctl (front_ctl),
        .o_job_mag (front_mag)
    );

    assign q_in = {front_ctl, front_mag};

    rits_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    rits_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_table     (table_bits),
        .i_job_valid (q_valid),
        .i_job_ctl   (t_job_ctl'(q_out[DATA_W-1 -: CTL_W])),
        .i_job_mag   (q_out[VALUE_BITS-1:0]),
        .o_job_pop   (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_bad_table (o_bad_table)
    );
endmodule
